// ===== rtl/exl_pkg.sv =====
// Shared types and constants for the expression lexer.
// Used by exl_front, exl_queue, exl_back and expression_lexer; no dependencies.
`default_nettype none

package exl_pkg;

    typedef enum logic [2:0] {
        KIND_NUMBER = 3'd0,
        KIND_IDENT  = 3'd1,
        KIND_OP     = 3'd2,
        KIND_LPAREN = 3'd3,
        KIND_RPAREN = 3'd4,
        KIND_END    = 3'd5,
        KIND_ERROR  = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TWO_DOTS = 2'd1,
        ERR_BAD_CHAR = 2'd2,
        ERR_TOO_LONG = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_NUM   = 2'd1,
        MODE_IDENT = 2'd2,
        MODE_DRAIN = 2'd3
    } lex_mode_t;

    typedef struct packed {
        kind_t        kind;
        logic [15:0]  start_pos;
        logic [16:0]  tok_length;
        logic [7:0]   tok_char;
        err_t         error_code;
    } lex_rec_t;

    // All records caused by one byte, in emission order
    typedef struct packed {
        lex_rec_t [2:0] rec;
        logic [1:0]     count;
    } lex_job_t;

    // Longest accepted input; positions beyond 16 bits always overflow
    localparam int unsigned MAX_INPUT_LEN = 65536;
    localparam logic [16:0] POS_LIMIT =
        (MAX_INPUT_LEN > 65536) ? 17'h10000 : 17'(MAX_INPUT_LEN);

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;

endpackage

`default_nettype wire

// ===== rtl/exl_front.sv =====
// Front end: takes one byte per cycle unless q_full, classifies it, updates the
// lexer state and pushes the records it causes as one job. Depends on exl_pkg.
`default_nettype none

module exl_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       ch,
    input  wire logic             final_byte,
    input  wire logic             q_full,
    output logic                  push,
    output exl_pkg::lex_job_t     push_job
);
    import exl_pkg::*;

    lex_mode_t   mode_reg, mode_next, mode_mid;
    logic [16:0] pos_reg, pos_next, pos_mid;
    logic [15:0] start_reg, start_next, start_mid;
    logic        dot_reg, dot_next, dot_mid;

    logic accept;
    logic is_digit, is_alpha, is_word, is_space, is_single, is_dot;
    logic active, too_long, cont, term, dot_err, num_dot, fresh;
    logic start_num, start_id, single, bad;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    assign is_digit  = ch inside {[CH_ZERO:CH_NINE]};
    assign is_alpha  = (ch inside {[CH_LOW_A:CH_LOW_Z]}) || (ch inside {[CH_UP_A:CH_UP_Z]});
    assign is_word   = is_alpha || is_digit || (ch == CH_UNDER);
    assign is_space  = ch inside {CH_SPACE, CH_TAB, CH_NL};
    assign is_dot    = (ch == CH_DOT);
    assign is_single = ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN};

    assign active   = (mode_reg != MODE_DRAIN);
    assign too_long = active && (pos_reg >= POS_LIMIT);
    assign cont     = ((mode_reg == MODE_NUM) && (is_digit || is_dot))
                   || ((mode_reg == MODE_IDENT) && is_word);
    assign term     = !too_long && ((mode_reg == MODE_NUM) || (mode_reg == MODE_IDENT)) && !cont;
    assign dot_err  = !too_long && (mode_reg == MODE_NUM) && is_dot && dot_reg;
    assign num_dot  = !too_long && (mode_reg == MODE_NUM) && is_dot && !dot_reg;
    // byte seen as in idle: either no token pending or the pending one just ended
    assign fresh    = active && !too_long && !cont;

    assign start_num = fresh && is_digit;
    assign start_id  = fresh && (is_alpha || (ch == CH_UNDER));
    assign single    = fresh && is_single;
    assign bad       = fresh && !is_space && !is_digit && !is_alpha
                    && (ch != CH_UNDER) && !is_single;

    // Next state
    always_comb
    begin
        mode_mid  = mode_reg;
        start_mid = start_reg;
        dot_mid   = dot_reg;
        pos_mid   = pos_reg;
        if (term)
        begin
            mode_mid = MODE_IDLE;
        end
        if (start_num)
        begin
            mode_mid  = MODE_NUM;
            start_mid = pos_reg[15:0];
            dot_mid   = 1'b0;
        end
        if (start_id)
        begin
            mode_mid  = MODE_IDENT;
            start_mid = pos_reg[15:0];
        end
        if (num_dot)
        begin
            dot_mid = 1'b1;
        end
        if (too_long || dot_err || bad)
        begin
            mode_mid = MODE_DRAIN;
        end
        if (active && !too_long)
        begin
            pos_mid = pos_reg + 17'd1;
        end

        if (final_byte)
        begin
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            start_next = '0;
            dot_next   = 1'b0;
        end
        else
        begin
            mode_next  = mode_mid;
            pos_next   = pos_mid;
            start_next = start_mid;
            dot_next   = dot_mid;
        end
    end

    // Outputs: records in emission order, packed from slot zero
    always_comb
    begin
        lex_rec_t   r;
        logic [1:0] cnt;
        push_job = '0;
        cnt      = 2'd0;

        r = '0;
        if (too_long)
        begin
            r.kind       = KIND_ERROR;
            r.start_pos  = pos_reg[16] ? 16'hFFFF : pos_reg[15:0];
            r.tok_char   = ch;
            r.error_code = ERR_TOO_LONG;
            push_job.rec[cnt] = r;
            cnt = cnt + 2'd1;
        end
        else if (dot_err)
        begin
            r.kind       = KIND_ERROR;
            r.start_pos  = pos_reg[15:0];
            r.tok_char   = ch;
            r.error_code = ERR_TWO_DOTS;
            push_job.rec[cnt] = r;
            cnt = cnt + 2'd1;
        end
        else if (term)
        begin
            r.kind       = (mode_reg == MODE_NUM) ? KIND_NUMBER : KIND_IDENT;
            r.start_pos  = start_reg;
            r.tok_length = pos_reg - {1'b0, start_reg};
            push_job.rec[cnt] = r;
            cnt = cnt + 2'd1;
        end

        r = '0;
        if (single || bad)
        begin
            r.start_pos = pos_reg[15:0];
            r.tok_char  = ch;
            if (bad)
            begin
                r.kind       = KIND_ERROR;
                r.error_code = ERR_BAD_CHAR;
            end
            else
            begin
                r.tok_length = 17'd1;
                case (ch)
                    CH_LPAREN: r.kind = KIND_LPAREN;
                    CH_RPAREN: r.kind = KIND_RPAREN;
                    default:   r.kind = KIND_OP;
                endcase
            end
            push_job.rec[cnt] = r;
            cnt = cnt + 2'd1;
        end

        r = '0;
        if (final_byte && ((mode_mid == MODE_NUM) || (mode_mid == MODE_IDENT)))
        begin
            r.kind       = (mode_mid == MODE_NUM) ? KIND_NUMBER : KIND_IDENT;
            r.start_pos  = start_mid;
            r.tok_length = pos_reg + 17'd1 - {1'b0, start_mid};
            push_job.rec[cnt] = r;
            cnt = cnt + 2'd1;
        end

        r = '0;
        if (final_byte)
        begin
            r.kind = KIND_END;
            push_job.rec[cnt] = r;
            cnt = cnt + 2'd1;
        end

        // at most three records: the end record lands in the last free slot
        push_job.count = cnt;
        push = accept && (too_long || dot_err || term || single || bad || final_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            dot_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            dot_reg   <= dot_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/exl_queue.sv =====
// Short job queue between the front and back ends of the lexer.
// Depends on exl_pkg for the job type.
`default_nettype none

module exl_queue #(
    parameter int unsigned DEPTH = exl_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire exl_pkg::lex_job_t push_job,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output exl_pkg::lex_job_t      head_job
);
    import exl_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    lex_job_t      slots [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_job   = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("job popped from an empty queue");

    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_job.count != 2'd0))
        else $error("job pushed with no records");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue fill count lost a push");

endmodule

`default_nettype wire

// ===== rtl/exl_back.sv =====
// Back end: walks the head job's records one per cycle while out_stall is low
// into out_rec_reg, retiring the job after its last record. Depends on exl_pkg.
`default_nettype none

module exl_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire exl_pkg::lex_job_t head_job,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output exl_pkg::lex_rec_t      out_rec,
    output logic                   run_last
);
    import exl_pkg::*;

    logic       out_valid_reg, out_valid_next;
    lex_rec_t   out_rec_reg, out_rec_next;
    logic       run_last_reg, run_last_next;
    logic [1:0] idx_reg, idx_next;
    logic       load, last;
    lex_rec_t   sel_rec;

    assign load = !out_valid_reg || !out_stall;
    assign last = (idx_reg == head_job.count - 2'd1);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_rec = head_job.rec[0];
            2'd1:    sel_rec = head_job.rec[1];
            2'd2:    sel_rec = head_job.rec[2];
            default: sel_rec = head_job.rec[0];
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_rec_next   = out_rec_reg;
        run_last_next  = run_last_reg;
        idx_next       = idx_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                out_rec_next  = sel_rec;
                run_last_next = last;
                // advance within the job, or retire it on its last record
                if (last)
                begin
                    idx_next = 2'd0;
                    pop      = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rec_reg  <= out_rec_next;
        run_last_reg <= run_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;
    assign run_last  = run_last_reg;

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < head_job.count))
        else $error("record index beyond head job");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid && run_last))
        else $error("job retired without a closing record");

    a_idx_reset_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == 2'd0))
        else $error("record index not rewound after job");

endmodule

`default_nettype wire

// ===== rtl/expression_lexer.sv =====
// Top level of the arithmetic expression lexer: front end, job queue, back end.
// Depends on exl_pkg, exl_front, exl_queue and exl_back.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------------
//   in      | sink      | in_valid / in_stall  | ch, final_byte
//   out     | source    | out_valid / out_stall| kind, start_pos, tok_length,
//           |           |                      | tok_char, error_code, run_last
//
// One byte is taken per cycle while the job queue has room; each byte's records
// (up to three) leave the output register one per cycle while out_stall is low,
// so the output port sets the sustained rate when bytes cause several records.
// Reset clears the lexer state, the queue pointers and the output valid.
// A stalled output fills the queue, and in_stall rises only once it is full.
`default_nettype none

module expression_lexer #(
    parameter int unsigned QUEUE_DEPTH = exl_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  ch,
    input  wire logic        final_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [15:0]      start_pos,
    output logic [16:0]      tok_length,
    output logic [7:0]       tok_char,
    output logic [1:0]       error_code,
    output logic             run_last
);
    import exl_pkg::*;

    logic     q_full, push, pop, head_valid;
    lex_job_t push_job, head_job;
    lex_rec_t out_rec;

    exl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ch         (ch),
        .final_byte (final_byte),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    exl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    exl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_rec    (out_rec),
        .run_last   (run_last)
    );

    assign kind       = out_rec.kind;
    assign start_pos  = out_rec.start_pos;
    assign tok_length = out_rec.tok_length;
    assign tok_char   = out_rec.tok_char;
    assign error_code = out_rec.error_code;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for expression_lexer: byte stream in, token words out.
// Depends on exl_pkg and the expression_lexer RTL; a built-in predictor
// tracks the lexer state and queues the token words each byte should produce.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import exl_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int SETTLE_CYCLES   = 20;

    typedef struct {
        lex_rec_t rec;
        logic     last;
    } token_word_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [7:0]  ch         = 8'd0;
    logic        final_byte = 1'b0;
    logic        out_stall  = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [2:0]  kind;
    logic [15:0] start_pos;
    logic [16:0] tok_length;
    logic [7:0]  tok_char;
    logic [1:0]  error_code;
    logic        run_last;

    // Predictor state
    logic [16:0] lex_pos       = '0;
    lex_mode_t   cur_mode      = MODE_IDLE;
    logic [15:0] tok_start     = '0;
    logic        dot_flag      = 1'b0;

    token_word_t expected_tokens[$];
    logic [7:0]  line_buf[$];
    int          fail_count    = 0;
    int          idle_cycles   = 0;
    int          stall_left    = 0;
    bit          idle_on       = 1'b1;
    bit          stall_on      = 1'b1;

    expression_lexer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ch         (ch),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .start_pos  (start_pos),
        .tok_length (tok_length),
        .tok_char   (tok_char),
        .error_code (error_code),
        .run_last   (run_last)
    );

    always #5 clk = ~clk;

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
    endfunction

    function automatic bit is_word_char(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    function automatic bit is_known_char(logic [7:0] c);
        return is_word_char(c) || c == CH_DOT || c == CH_SPACE || c == CH_TAB
            || c == CH_NL || c == CH_PLUS || c == CH_MINUS || c == CH_STAR
            || c == CH_SLASH || c == CH_LPAREN || c == CH_RPAREN;
    endfunction

    function automatic token_word_t make_word(kind_t k, logic [15:0] s, logic [16:0] len,
                                              logic [7:0] c, err_t e);
        token_word_t w;
        w.rec.kind       = k;
        w.rec.start_pos  = s;
        w.rec.tok_length = len;
        w.rec.tok_char   = c;
        w.rec.error_code = e;
        w.last           = 1'b0;
        return w;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_char(input logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endtask

    // Advance the lexer state by one byte and queue the token words it causes
    task automatic lex_predict_byte(input logic [7:0] c, input logic fin);
        token_word_t run[$];
        logic [16:0] p;
        bit          taken;
        p = lex_pos;
        taken = 1'b0;
        if (cur_mode != MODE_DRAIN) begin
            if (p > 17'hFFFF || {15'd0, p} >= MAX_INPUT_LEN) begin
                run.insert(run.size(),
                           make_word(KIND_ERROR, (p > 17'hFFFF) ? 16'hFFFF : p[15:0],
                                     '0, c, ERR_TOO_LONG));
                cur_mode = MODE_DRAIN;
            end else begin
                if (cur_mode == MODE_NUM) begin
                    if (is_digit(c)) begin
                        taken = 1'b1;
                    end else if (c == CH_DOT) begin
                        taken = 1'b1;
                        if (dot_flag) begin
                            run.insert(run.size(), make_word(KIND_ERROR, p[15:0], '0, c,
                                                             ERR_TWO_DOTS));
                            cur_mode = MODE_DRAIN;
                        end else begin
                            dot_flag = 1'b1;
                        end
                    end else begin
                        run.insert(run.size(),
                                   make_word(KIND_NUMBER, tok_start,
                                             17'(p - {1'b0, tok_start}), '0, ERR_NONE));
                        cur_mode = MODE_IDLE;
                    end
                end else if (cur_mode == MODE_IDENT) begin
                    if (is_word_char(c)) begin
                        taken = 1'b1;
                    end else begin
                        run.insert(run.size(),
                                   make_word(KIND_IDENT, tok_start,
                                             17'(p - {1'b0, tok_start}), '0, ERR_NONE));
                        cur_mode = MODE_IDLE;
                    end
                end
                if (!taken) begin
                    if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
                        taken = 1'b1;
                    end else if (is_digit(c)) begin
                        cur_mode  = MODE_NUM;
                        tok_start = p[15:0];
                        dot_flag  = 1'b0;
                    end else if (is_alpha(c) || c == CH_UNDER) begin
                        cur_mode  = MODE_IDENT;
                        tok_start = p[15:0];
                    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR
                                 || c == CH_SLASH) begin
                        run.insert(run.size(),
                                   make_word(KIND_OP, p[15:0], 17'd1, c, ERR_NONE));
                    end else if (c == CH_LPAREN) begin
                        run.insert(run.size(),
                                   make_word(KIND_LPAREN, p[15:0], 17'd1, c, ERR_NONE));
                    end else if (c == CH_RPAREN) begin
                        run.insert(run.size(),
                                   make_word(KIND_RPAREN, p[15:0], 17'd1, c, ERR_NONE));
                    end else begin
                        run.insert(run.size(),
                                   make_word(KIND_ERROR, p[15:0], '0, c, ERR_BAD_CHAR));
                        cur_mode = MODE_DRAIN;
                    end
                end
                lex_pos = p + 17'd1;
            end
        end
        if (fin) begin
            if (cur_mode == MODE_NUM)
                run.insert(run.size(),
                           make_word(KIND_NUMBER, tok_start,
                                     17'(p + 17'd1 - {1'b0, tok_start}), '0, ERR_NONE));
            else if (cur_mode == MODE_IDENT)
                run.insert(run.size(),
                           make_word(KIND_IDENT, tok_start,
                                     17'(p + 17'd1 - {1'b0, tok_start}), '0, ERR_NONE));
            run.insert(run.size(), make_word(KIND_END, '0, '0, '0, ERR_NONE));
            lex_pos   = '0;
            cur_mode  = MODE_IDLE;
            tok_start = '0;
            dot_flag  = 1'b0;
        end
        if (run.size() > 0)
            run[run.size() - 1].last = 1'b1;
        foreach (run[i])
            expected_tokens.insert(expected_tokens.size(), run[i]);
    endtask

    // Entered and left at a falling edge; valid stays high between back-to-back bytes
    task automatic send_byte(input logic [7:0] c, input logic fin);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        ch         = c;
        final_byte = fin;
        do
            @(posedge clk);
        while (in_stall);
        lex_predict_byte(c, fin);
        @(negedge clk);
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_byte(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic load_text(input string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    task automatic wait_drained();
        while (expected_tokens.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return CH_LOW_A + 8'(r);
        else if (r < 52)
            return CH_UP_A + 8'(r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 2))
            0: return CH_SPACE;
            1: return CH_TAB;
            default: return CH_NL;
        endcase
    endfunction

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // Fill line_buf with an expression; some lines are noise or carry a fault
    task automatic build_line();
        int         r;
        int         n;
        int         dot_at;
        int         at;
        logic [7:0] bad;
        line_buf.delete();
        r = $urandom_range(0, 99);
        if (r < 12) begin
            n = $urandom_range(1, 12);
            repeat (n)
                add_char(8'($urandom_range(0, 255)));
            return;
        end
        n = $urandom_range(1, 8);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    add_char(pick_digit());
                    at = $urandom_range(0, 5);
                    dot_at = $urandom_range(0, at + 2);
                    for (int i = 0; i < at; i++) begin
                        if (i == dot_at)
                            add_char(CH_DOT);
                        add_char(pick_digit());
                    end
                end
                3, 4: begin
                    add_char(pick_letter());
                    at = $urandom_range(0, 5);
                    repeat (at)
                        add_char($urandom_range(0, 3) == 0 ? pick_digit() : pick_letter());
                end
                5, 6: add_char(pick_op());
                7: add_char(CH_LPAREN);
                8: add_char(CH_RPAREN);
                default: add_char(pick_space());
            endcase
            if ($urandom_range(0, 99) < 30)
                add_char(pick_space());
        end
        if (r < 20) begin
            do
                bad = 8'($urandom_range(0, 255));
            while (is_known_char(bad));
            line_buf.insert($urandom_range(0, line_buf.size()), bad);
        end else if (r < 27) begin
            at = $urandom_range(0, line_buf.size());
            line_buf.insert(at, CH_DOT);
            line_buf.insert(at, pick_digit());
            line_buf.insert(at, CH_DOT);
            line_buf.insert(at, pick_digit());
        end
    endtask

    task automatic test_directed();
        load_text("1.5+_x\t-(y2)/3 \nz");
        send_line();
        load_text("7.2.1");
        send_line();
        send_byte(8'h00, 1'b1);
        send_byte(CH_ZERO + 8'd8, 1'b1);
    endtask

    task automatic test_random_lines(input int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            build_line();
            send_line();
            sent += line_buf.size();
        end
    endtask

    // Hold the sender mid-line until every pending word is out, then resume
    task automatic test_pause_until_drained();
        int half;
        load_text("ab12 + (3.75*x_9) - q");
        half = line_buf.size() / 2;
        for (int i = 0; i < half; i++)
            send_byte(line_buf[i], 1'b0);
        in_valid = 1'b0;
        wait_drained();
        @(negedge clk);
        for (int i = half; i < line_buf.size(); i++)
            send_byte(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic test_back_to_back_lines(input int budget);
        idle_on  = 1'b0;
        stall_on = 1'b0;
        test_random_lines(budget);
        stall_on = 1'b1;
    endtask

    // Receiver backpressure
    always @(negedge clk) begin
        if (stall_left != 0) begin
            out_stall = 1'b1;
            stall_left--;
        end else begin
            out_stall = 1'b0;
            if (stall_on && $urandom_range(0, 99) < 25)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk) begin
        token_word_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_tokens.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("tb: unexpected word kind=%0d start=%0d len=%0d", kind,
                             start_pos, tok_length);
            end else begin
                want = expected_tokens.pop_front();
                if (kind !== want.rec.kind || start_pos !== want.rec.start_pos
                    || tok_length !== want.rec.tok_length
                    || tok_char !== want.rec.tok_char
                    || error_code !== want.rec.error_code || run_last !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"tb: word mismatch exp kind=%0d start=%0d len=%0d ",
                                  "char=%02h err=%0d last=%0d got kind=%0d start=%0d ",
                                  "len=%0d char=%02h err=%0d last=%0d"},
                                 want.rec.kind, want.rec.start_pos, want.rec.tok_length,
                                 want.rec.tok_char, want.rec.error_code, want.last,
                                 kind, start_pos, tok_length, tok_char, error_code,
                                 run_last);
                end
            end
        end
    end

    // Abort when neither side has moved a word for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_lines(150);
        test_pause_until_drained();
        test_back_to_back_lines(130);

        in_valid = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && expected_tokens.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
